### hw/rtl/dss_pkg.sv
`default_nettype none

package dss_pkg;

  localparam int SAMPLE_W = 20;
  localparam int SPB_W    = 7;
  localparam int BAR_W    = 8;
  localparam int IDX_W    = 6;

  typedef enum logic [1:0] {
    VOICE_REST  = 2'd0,
    VOICE_KICK  = 2'd1,
    VOICE_HIHAT = 2'd2,
    VOICE_SNARE = 2'd3
  } voice_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_SAMPLES_PER_STEP = 3'd0,
    REG_STEPS_PER_BAR    = 3'd1,
    REG_BAR_COUNT        = 3'd2,
    REG_KICK_LENGTH      = 3'd3,
    REG_HIHAT_LENGTH     = 3'd4,
    REG_SNARE_LENGTH     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] samples_per_step;
    logic [SPB_W-1:0]    steps_per_bar;
    logic [BAR_W-1:0]    bar_count;
    logic [SAMPLE_W-1:0] kick_length;
    logic [SAMPLE_W-1:0] hihat_length;
    logic [SAMPLE_W-1:0] snare_length;
  } cfg_t;

  // position of one tick in the song, as seen when it is accepted
  typedef struct packed {
    logic                done;
    logic                first;
    logic                song_last;
    logic [SAMPLE_W-1:0] sample;
  } tick_t;

endpackage

`default_nettype wire

### hw/rtl/dss_ram.sv
`default_nettype none

module dss_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dss_timing.sv
`default_nettype none

module dss_timing #(
  parameter int MAX_STEPS = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire dss_pkg::cfg_t                         cfg,
  input  wire logic                                  advance,
  output dss_pkg::tick_t                             info,
  output logic [((MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1)-1:0] step_addr
);

  localparam int AW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int SBW = $clog2(MAX_STEPS + 1);
  localparam int CW  = (SBW > dss_pkg::SPB_W) ? SBW : dss_pkg::SPB_W;
  localparam int SW  = dss_pkg::SAMPLE_W;
  localparam int BW  = dss_pkg::BAR_W;

  logic [SW-1:0] sample_in_step;
  logic [AW-1:0] step_in_bar;
  logic [BW-1:0] bar_number;
  logic          finished;

  logic [SW-1:0] sps_eff;
  logic [CW-1:0] spb_raw;
  logic [CW-1:0] spb_eff;
  logic [BW-1:0] bars_eff;
  logic          step_last;
  logic          bar_last;
  logic          song_last;

  always_comb begin
    sps_eff  = (cfg.samples_per_step == '0) ? SW'(1) : cfg.samples_per_step;
    bars_eff = (cfg.bar_count == '0) ? BW'(1) : cfg.bar_count;
    spb_raw  = CW'(cfg.steps_per_bar);
    if (spb_raw == '0) begin
      spb_eff = CW'(1);
    end else if (spb_raw > CW'(MAX_STEPS)) begin
      spb_eff = CW'(MAX_STEPS);
    end else begin
      spb_eff = spb_raw;
    end
    step_last = ((SW+1)'(sample_in_step) + (SW+1)'(1)) >= (SW+1)'(sps_eff);
    bar_last  = step_last
              && (((CW+1)'(step_in_bar) + (CW+1)'(1)) >= (CW+1)'(spb_eff));
    song_last = bar_last && (((BW+1)'(bar_number) + (BW+1)'(1)) >= (BW+1)'(bars_eff));
  end

  assign info.done      = finished;
  assign info.first     = (sample_in_step == '0);
  assign info.song_last = song_last;
  assign info.sample    = sample_in_step;
  assign step_addr      = step_in_bar;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_in_step <= '0;
      step_in_bar    <= '0;
      bar_number     <= '0;
      finished       <= 1'b0;
    end else if (advance && !finished) begin
      if (song_last) begin
        finished       <= 1'b1;
        sample_in_step <= '0;
        step_in_bar    <= '0;
        bar_number     <= '0;
      end else if (bar_last) begin
        sample_in_step <= '0;
        step_in_bar    <= '0;
        bar_number     <= bar_number + BW'(1);
      end else if (step_last) begin
        sample_in_step <= '0;
        step_in_bar    <= step_in_bar + AW'(1);
      end else begin
        sample_in_step <= sample_in_step + SW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dss_voice.sv
`default_nettype none

module dss_voice #(
  parameter int OFFSET_BITS = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire dss_pkg::cfg_t                   cfg,
  input  wire logic                            load,
  input  wire dss_pkg::tick_t                  info_in,
  input  wire dss_pkg::voice_t                 pat_voice,
  output logic                                 take_ok,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output dss_pkg::voice_t                      out_voice,
  output logic [dss_pkg::SAMPLE_W-1:0]         out_offset,
  output logic                                 out_song_end,
  output logic                                 out_done
);

  localparam int SW = dss_pkg::SAMPLE_W;
  localparam int OB = (OFFSET_BITS < SW) ? OFFSET_BITS : SW;
  localparam logic [SW-1:0] OFF_MASK = SW'((64'd1 << OB) - 64'd1);

  logic            s1_valid;
  dss_pkg::tick_t  s1_info;
  dss_pkg::voice_t cur_voice;

  logic            out_free;
  logic            s1_move;
  dss_pkg::voice_t vsel;
  logic [SW-1:0]   vlen;
  logic            sounding;

  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  assign take_ok  = !s1_valid || out_free;

  // voice is latched from the pattern on the first sample of a step
  assign vsel = s1_info.first ? pat_voice : cur_voice;

  always_comb begin
    unique case (vsel)
      dss_pkg::VOICE_KICK:  vlen = cfg.kick_length;
      dss_pkg::VOICE_HIHAT: vlen = cfg.hihat_length;
      dss_pkg::VOICE_SNARE: vlen = cfg.snare_length;
      default:              vlen = '0;
    endcase
  end

  assign sounding = (vsel != dss_pkg::VOICE_REST) && (s1_info.sample < vlen);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      cur_voice <= dss_pkg::VOICE_REST;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_move && !s1_info.done) begin
        cur_voice <= vsel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_info <= info_in;
    end
    if (s1_move) begin
      if (s1_info.done) begin
        out_voice    <= dss_pkg::VOICE_REST;
        out_offset   <= '0;
        out_song_end <= 1'b0;
        out_done     <= 1'b1;
      end else begin
        out_voice    <= sounding ? vsel : dss_pkg::VOICE_REST;
        out_offset   <= sounding ? (s1_info.sample & OFF_MASK) : '0;
        out_song_end <= s1_info.song_last;
        out_done     <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/drum_step_sequencer.sv
`default_nettype none

// drum step sequencer: input beats are either a pattern write (s_tuser low: one voice code
// for one step of the bar) or a tick (s_tuser high) that stands for one output audio
// sample. every tick yields exactly one output beat naming the sounding voice and the read
// offset into that voice's sample memory; pattern writes yield none. the one-bar pattern
// repeats for every bar; a hit sounds from offset 0 until its step ends or its sample runs
// out. m_tlast marks the final sample of the song, after which every tick is silent with
// m_tuser set, until reset. one beat is taken every clock cycle while the output is not
// stalled. a tick's result passes the registered read of the pattern memory, then the
// output register. the pattern memory lives in a one-read one-write ram, cleared at
// reset through a row of valid bits, so no clearing pass is needed. configuration sits
// behind an apb port; the user writes it only while the block is idle, unenforced here.
module drum_step_sequencer #(
  parameter int MAX_STEPS   = 64,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // step_index[5:0], step_voice[7:6]
  input  wire logic        s_tuser,   // op: 0 pattern write, 1 tick
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // voice[1:0], sample_offset[21:2], zero pad[23:22]
  output logic             m_tlast,   // song_end
  output logic             m_tuser,   // done_res
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int SW = dss_pkg::SAMPLE_W;

  // configuration registers
  dss_pkg::cfg_t     cfg;
  dss_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = dss_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_step <= SW'(1);
      cfg.steps_per_bar    <= dss_pkg::SPB_W'(16);
      cfg.bar_count        <= dss_pkg::BAR_W'(1);
      cfg.kick_length      <= '0;
      cfg.hihat_length     <= '0;
      cfg.snare_length     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dss_pkg::REG_SAMPLES_PER_STEP: cfg.samples_per_step <= pwdata[SW-1:0];
        dss_pkg::REG_STEPS_PER_BAR:    cfg.steps_per_bar    <= pwdata[dss_pkg::SPB_W-1:0];
        dss_pkg::REG_BAR_COUNT:        cfg.bar_count        <= pwdata[dss_pkg::BAR_W-1:0];
        dss_pkg::REG_KICK_LENGTH:      cfg.kick_length      <= pwdata[SW-1:0];
        dss_pkg::REG_HIHAT_LENGTH:     cfg.hihat_length     <= pwdata[SW-1:0];
        dss_pkg::REG_SNARE_LENGTH:     cfg.snare_length     <= pwdata[SW-1:0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dss_pkg::REG_SAMPLES_PER_STEP: prdata = 32'(cfg.samples_per_step);
      dss_pkg::REG_STEPS_PER_BAR:    prdata = 32'(cfg.steps_per_bar);
      dss_pkg::REG_BAR_COUNT:        prdata = 32'(cfg.bar_count);
      dss_pkg::REG_KICK_LENGTH:      prdata = 32'(cfg.kick_length);
      dss_pkg::REG_HIHAT_LENGTH:     prdata = 32'(cfg.hihat_length);
      dss_pkg::REG_SNARE_LENGTH:     prdata = 32'(cfg.snare_length);
      default:                       prdata = '0;
    endcase
  end

  // input beat decode
  logic                    in_beat;
  logic                    tick_acc;
  logic                    wr_acc;
  logic [dss_pkg::IDX_W-1:0] in_idx;
  logic [1:0]              in_voice;

  assign in_idx   = s_tdata[5:0];
  assign in_voice = s_tdata[7:6];
  assign in_beat  = s_tvalid && s_tready;
  assign tick_acc = in_beat && (dss_pkg::op_t'(s_tuser) == dss_pkg::OP_TICK);
  // writes to steps beyond the pattern memory are dropped
  assign wr_acc   = in_beat && (dss_pkg::op_t'(s_tuser) == dss_pkg::OP_WRITE)
                 && (32'(in_idx) < 32'(MAX_STEPS));

  // song position counters
  dss_pkg::tick_t tinfo;
  logic [AW-1:0]  step_addr;

  dss_timing #(
    .MAX_STEPS (MAX_STEPS)
  ) u_timing (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (tick_acc),
    .info      (tinfo),
    .step_addr (step_addr)
  );

  // pattern memory, with one valid bit per step standing in for the reset clear
  logic [MAX_STEPS-1:0] pat_valid;
  logic                 rd_valid;
  logic [1:0]           rd_data;
  logic [AW-1:0]        wr_addr;

  assign wr_addr = AW'(in_idx);

  dss_ram #(
    .WIDTH (2),
    .DEPTH (MAX_STEPS)
  ) u_pattern (
    .clk   (clk),
    .we    (wr_acc),
    .waddr (wr_addr),
    .wdata (in_voice),
    .re    (tick_acc),
    .raddr (step_addr),
    .rdata (rd_data)
  );

  // a write and a tick never share a cycle, so a tick always sees every earlier write
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_acc) begin
        pat_valid[wr_addr] <= 1'b1;
      end
      if (tick_acc) begin
        rd_valid <= pat_valid[step_addr];
      end
    end
  end

  // voice resolution and output register
  dss_pkg::voice_t pat_voice;
  dss_pkg::voice_t out_voice;
  logic [SW-1:0]   out_offset;
  logic            take_ok;

  assign pat_voice = rd_valid ? dss_pkg::voice_t'(rd_data) : dss_pkg::VOICE_REST;

  dss_voice #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_voice (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .load         (tick_acc),
    .info_in      (tinfo),
    .pat_voice    (pat_voice),
    .take_ok      (take_ok),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_voice    (out_voice),
    .out_offset   (out_offset),
    .out_song_end (m_tlast),
    .out_done     (m_tuser)
  );

  assign s_tready = take_ok;
  assign m_tdata  = {2'b00, out_offset, out_voice};

  // a song-end beat is never also a done beat
  a_end_not_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser)
    else $error("song end flagged on a done beat");

  // the song finishes only on a tick that was the last of the song
  a_finish_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(tinfo.done) |-> $past(tick_acc && tinfo.song_last))
    else $error("finished set without a final tick");

  // input back-pressure only while both the stage and the output register are held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with room downstream");

  // a silent beat carries a zero offset
  a_silent_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_voice == dss_pkg::VOICE_REST) |-> (out_offset == '0))
    else $error("silent beat with non-zero offset");

endmodule

`default_nettype wire
